@@ rtl/psalf_pkg.sv @@
// ----------------------------------------------------------------------------
// psalf_pkg
// Shared widths, the emitted point record and a helper to build one for the
// polyline split block.
// ----------------------------------------------------------------------------
package psalf_pkg;

  // coordinate and length formats
  localparam int COORD_BITS       = 16;
  localparam int LENGTH_FRAC_BITS = 8;
  localparam int LEN_BITS         = COORD_BITS + 2 + LENGTH_FRAC_BITS;
  localparam int FRAC_BITS        = 17;
  localparam int FRAC_SHIFT       = FRAC_BITS - 1;

  // internal arithmetic widths
  localparam int MAG_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS   = 2 * MAG_BITS;
  localparam int REM_BITS  = MAG_BITS + 3;
  localparam int PROD_BITS = LEN_BITS + FRAC_BITS;
  localparam int CNT_BITS  = $clog2(((FRAC_BITS > MAG_BITS) ? FRAC_BITS : MAG_BITS) + 1);

  // up to three points leave for one vertex
  localparam int SLOTS = 3;

  // part codes
  localparam logic PART_FIRST  = 1'b0;
  localparam logic PART_SECOND = 1'b1;

  // status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         part;
    logic                         status;
    logic                         last;
  } point_t;

  function automatic point_t pack_point(
    input logic signed [COORD_BITS-1:0] x,
    input logic signed [COORD_BITS-1:0] y,
    input logic                         part,
    input logic                         status,
    input logic                         last
  );
    point_t p;
    p.x      = x;
    p.y      = y;
    p.part   = part;
    p.status = status;
    p.last   = last;
    return p;
  endfunction

endpackage

@@ rtl/psalf_in_if.sv @@
// ----------------------------------------------------------------------------
// psalf_in_if
// Vertex channel: valid/ready handshake with one polyline vertex per transfer.
// ----------------------------------------------------------------------------
interface psalf_in_if import psalf_pkg::*; ();

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         first_vertex;
  logic                         last_vertex;
  logic [FRAC_BITS-1:0]         split_fraction;
  logic [LEN_BITS-1:0]          path_length;

  modport source (
    output valid, vertex_x, vertex_y, first_vertex, last_vertex,
    output split_fraction, path_length,
    input  ready
  );

  modport sink (
    input  valid, vertex_x, vertex_y, first_vertex, last_vertex,
    input  split_fraction, path_length,
    output ready
  );

endinterface

@@ rtl/psalf_out_if.sv @@
// ----------------------------------------------------------------------------
// psalf_out_if
// Point channel: valid/ready handshake with one emitted point per transfer.
// ----------------------------------------------------------------------------
interface psalf_out_if import psalf_pkg::*; ();

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         part_select;
  logic                         status;
  logic                         run_end;

  modport source (
    output valid, point_x, point_y, part_select, status, run_end,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, part_select, status, run_end,
    output ready
  );

endinterface

@@ rtl/polyline_split_at_length_fraction.sv @@
// ----------------------------------------------------------------------------
// polyline_split_at_length_fraction
// Splits a stream of polyline vertices at a fraction of the path length.
// ----------------------------------------------------------------------------
// Vertices enter on the vertices channel, one per transfer; the first vertex
// of a polyline carries the total length (Q18.8) and the split fraction
// (Q1.16). Points leave on the points channel, up to three per vertex, with
// run_end high on the last point of each vertex.
// One vertex is worked on at a time; ready is high only while idle.
// First vertex: bit-serial multiply for the split length, then its point
// goes to the output register.
// Vertex before the split: bit-serial squaring, digit-by-digit square root
// and a compare; the vertex that crosses the split adds a serial
// interpolation.
// Vertex after the split, or with a whole-path fraction: queued directly.
// Each point then moves in turn into the output register, which holds the
// final point while the next vertex is already accepted.
// A stalled receiver holds the output register and stops the point queue.
// Reset (synchronous) clears the polyline state as if a path from the origin
// with split length zero were in progress, and empties the output.
// ----------------------------------------------------------------------------
module polyline_split_at_length_fraction import psalf_pkg::*; (
  input logic      clk,
  input logic      rst,
  psalf_in_if.sink vertices,
  psalf_out_if.source points
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_SQ     = 3'd2;
  localparam logic [2:0] S_ROOT   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]                   state;

  // polyline state
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic [LEN_BITS-1:0]          walked_length;
  logic [LEN_BITS-1:0]          target_length;
  logic                         split_done;
  logic                         take_all;
  logic                         rejected;

  // current vertex
  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic signed [MAG_BITS-1:0]   dx_r;
  logic signed [MAG_BITS-1:0]   dy_r;
  logic [CNT_BITS-1:0]          cnt;

  // split length multiply
  logic [FRAC_BITS-1:0]         frac_sr;
  logic [LEN_BITS-1:0]          plen;
  logic [PROD_BITS-1:0]         prod;

  // square sum and root
  logic [MAG_BITS-1:0]          ax;
  logic [MAG_BITS-1:0]          ay;
  logic [MAG_BITS-1:0]          ax_sr;
  logic [MAG_BITS-1:0]          ay_sr;
  logic [SQ_BITS-1:0]           sq;
  logic [REM_BITS-1:0]          rem;
  logic [MAG_BITS-1:0]          root;

  // point queue and output register
  point_t                       slot [SLOTS];
  logic [1:0]                   slot_cnt;
  point_t                       out_pt;
  logic                         out_valid;

  logic                         accept;
  logic                         out_load;
  logic signed [MAG_BITS-1:0]   dx;
  logic signed [MAG_BITS-1:0]   dy;
  logic [MAG_BITS-1:0]          dx_abs;
  logic [MAG_BITS-1:0]          dy_abs;
  logic [PROD_BITS-1:0]         prod_next;
  logic [LEN_BITS-1:0]          target_sat;
  logic [SQ_BITS-1:0]           sq_next;
  logic [REM_BITS-1:0]          rem_sh;
  logic [REM_BITS-1:0]          trial;
  logic                         root_ge;
  logic [LEN_BITS-1:0]          seg;
  logic [LEN_BITS:0]            sum;
  logic [LEN_BITS-1:0]          sum_sat;
  logic [LEN_BITS-1:0]          num;
  logic                         over;
  logic                         hit;
  logic                         div_start;
  logic                         ix_done;
  logic                         iy_done;
  logic signed [COORD_BITS-1:0] split_x;
  logic signed [COORD_BITS-1:0] split_y;

  // handshakes
  assign vertices.ready = (state == S_IDLE) && !rst;
  assign accept         = vertices.valid && vertices.ready;
  assign out_load       = (state == S_EMIT) && (!out_valid || points.ready);

  // step from the previous vertex
  always_comb begin
    dx     = MAG_BITS'(vertices.vertex_x) - MAG_BITS'(prev_x);
    dy     = MAG_BITS'(vertices.vertex_y) - MAG_BITS'(prev_y);
    dx_abs = dx[MAG_BITS-1] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
    dy_abs = dy[MAG_BITS-1] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
  end

  // shift-add multiply, fraction msb first, and saturated split length
  always_comb begin
    prod_next  = {prod[PROD_BITS-2:0], 1'b0}
               + (frac_sr[FRAC_BITS-1] ? PROD_BITS'(plen) : '0);
    target_sat = prod_next[PROD_BITS-1] ? '1
               : prod_next[LEN_BITS+FRAC_SHIFT-1:FRAC_SHIFT];
  end

  // squares of both axes, one multiplier bit per cycle
  assign sq_next = {sq[SQ_BITS-2:0], 1'b0}
                 + (ax_sr[MAG_BITS-1] ? SQ_BITS'(ax) : '0)
                 + (ay_sr[MAG_BITS-1] ? SQ_BITS'(ay) : '0);

  // restoring square root, two radicand bits per cycle
  always_comb begin
    rem_sh  = {rem[REM_BITS-3:0], sq[SQ_BITS-1 -: 2]};
    trial   = REM_BITS'({root, 2'b01});
    root_ge = (rem_sh >= trial);
  end

  // segment length against the split length
  always_comb begin
    seg     = LEN_BITS'({root, {LENGTH_FRAC_BITS{1'b0}}});
    sum     = (LEN_BITS + 1)'(walked_length) + (LEN_BITS + 1)'(seg);
    sum_sat = sum[LEN_BITS] ? '1 : sum[LEN_BITS-1:0];
    num     = (target_length > walked_length) ? (target_length - walked_length) : '0;
    over    = (sum > (LEN_BITS + 1)'(target_length));
    hit     = (sum == (LEN_BITS + 1)'(target_length));
  end

  assign div_start = (state == S_DECIDE) && over;

  // split point, one unit per axis
  psalf_interp u_interp_x (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .base  (prev_x),
    .delta (dx_r),
    .num   (num),
    .len   (seg),
    .done  (ix_done),
    .point (split_x)
  );

  psalf_interp u_interp_y (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .base  (prev_y),
    .delta (dy_r),
    .num   (num),
    .len   (seg),
    .done  (iy_done),
    .point (split_y)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      prev_x        <= '0;
      prev_y        <= '0;
      walked_length <= '0;
      target_length <= '0;
      split_done    <= 1'b0;
      take_all      <= 1'b0;
      rejected      <= 1'b0;
      cnt           <= '0;
      slot_cnt      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (vertices.first_vertex) begin
              // new polyline
              prev_x        <= vertices.vertex_x;
              prev_y        <= vertices.vertex_y;
              walked_length <= '0;
              split_done    <= 1'b0;
              take_all      <= vertices.split_fraction[FRAC_BITS-1];
              rejected      <= (vertices.path_length == '0) || vertices.last_vertex;
              if ((vertices.path_length == '0) || vertices.last_vertex) begin
                slot[0] <= pack_point('0, '0, PART_FIRST, STATUS_REJECT, 1'b1);
              end else begin
                slot[0] <= pack_point(vertices.vertex_x, vertices.vertex_y,
                                      PART_FIRST, STATUS_OK, 1'b1);
              end
              slot_cnt <= 2'd1;
              frac_sr  <= vertices.split_fraction;
              plen     <= vertices.path_length;
              prod     <= '0;
              cnt      <= CNT_BITS'(FRAC_BITS);
              state    <= S_MUL;
            end else if (rejected) begin
              // rejected polyline: vertex dropped
            end else if (take_all || split_done) begin
              slot[0]  <= pack_point(vertices.vertex_x, vertices.vertex_y,
                                     take_all ? PART_FIRST : PART_SECOND,
                                     STATUS_OK, 1'b1);
              slot_cnt <= 2'd1;
              prev_x   <= vertices.vertex_x;
              prev_y   <= vertices.vertex_y;
              state    <= S_EMIT;
            end else begin
              cur_x <= vertices.vertex_x;
              cur_y <= vertices.vertex_y;
              dx_r  <= dx;
              dy_r  <= dy;
              ax    <= dx_abs;
              ay    <= dy_abs;
              ax_sr <= dx_abs;
              ay_sr <= dy_abs;
              sq    <= '0;
              cnt   <= CNT_BITS'(MAG_BITS);
              state <= S_SQ;
            end
          end
        end

        S_MUL: begin
          prod    <= prod_next;
          frac_sr <= {frac_sr[FRAC_BITS-2:0], 1'b0};
          cnt     <= cnt - CNT_BITS'(1);
          if (cnt == CNT_BITS'(1)) begin
            target_length <= target_sat;
            state         <= S_EMIT;
          end
        end

        S_SQ: begin
          sq    <= sq_next;
          ax_sr <= {ax_sr[MAG_BITS-2:0], 1'b0};
          ay_sr <= {ay_sr[MAG_BITS-2:0], 1'b0};
          if (cnt == CNT_BITS'(1)) begin
            rem   <= '0;
            root  <= '0;
            cnt   <= CNT_BITS'(MAG_BITS);
            state <= S_ROOT;
          end else begin
            cnt <= cnt - CNT_BITS'(1);
          end
        end

        S_ROOT: begin
          rem  <= root_ge ? (rem_sh - trial) : rem_sh;
          root <= {root[MAG_BITS-2:0], root_ge};
          sq   <= {sq[SQ_BITS-3:0], 2'b00};
          cnt  <= cnt - CNT_BITS'(1);
          if (cnt == CNT_BITS'(1)) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          walked_length <= sum_sat;
          prev_x        <= cur_x;
          prev_y        <= cur_y;
          if (over) begin
            split_done <= 1'b1;
            state      <= S_DIV;
          end else if (hit) begin
            split_done <= 1'b1;
            slot[0]    <= pack_point(cur_x, cur_y, PART_FIRST, STATUS_OK, 1'b0);
            slot[1]    <= pack_point(cur_x, cur_y, PART_SECOND, STATUS_OK, 1'b1);
            slot_cnt   <= 2'd2;
            state      <= S_EMIT;
          end else begin
            slot[0]  <= pack_point(cur_x, cur_y, PART_FIRST, STATUS_OK, 1'b1);
            slot_cnt <= 2'd1;
            state    <= S_EMIT;
          end
        end

        S_DIV: begin
          if (ix_done && iy_done) begin
            slot[0]  <= pack_point(split_x, split_y, PART_FIRST, STATUS_OK, 1'b0);
            slot[1]  <= pack_point(split_x, split_y, PART_SECOND, STATUS_OK, 1'b0);
            slot[2]  <= pack_point(cur_x, cur_y, PART_SECOND, STATUS_OK, 1'b1);
            slot_cnt <= 2'd3;
            state    <= S_EMIT;
          end
        end

        S_EMIT: begin
          // queue advances on each move into the output register
          if (out_load) begin
            slot[0]  <= slot[1];
            slot[1]  <= slot[2];
            slot_cnt <= slot_cnt - 2'd1;
            if (slot_cnt == 2'd1) begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (points.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pt <= slot[0];
    end
  end

  assign points.valid       = out_valid;
  assign points.point_x     = out_pt.x;
  assign points.point_y     = out_pt.y;
  assign points.part_select = out_pt.part;
  assign points.status      = out_pt.status;
  assign points.run_end     = out_pt.last;

endmodule

@@ rtl/psalf_interp.sv @@
// ----------------------------------------------------------------------------
// psalf_interp
// One axis of the split point: base + delta * num / len, truncated toward
// zero, with num < len. Bit-serial over the magnitude of delta, one bit per
// cycle, keeping quotient and remainder of delta * num / len.
// ----------------------------------------------------------------------------
module psalf_interp import psalf_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] base,
  input  logic signed [MAG_BITS-1:0]   delta,
  input  logic [LEN_BITS-1:0]          num,
  input  logic [LEN_BITS-1:0]          len,
  output logic                         done,
  output logic signed [COORD_BITS-1:0] point
);

  localparam int R2_BITS  = LEN_BITS + 2;
  localparam int SUM_BITS = COORD_BITS + 2;

  logic                         busy;
  logic [CNT_BITS-1:0]          cnt;
  logic [MAG_BITS-1:0]          mag_sr;
  logic                         neg;
  logic                         pos;
  logic signed [COORD_BITS-1:0] base_r;
  logic [LEN_BITS-1:0]          num_r;
  logic [LEN_BITS-1:0]          len_r;
  logic [MAG_BITS-1:0]          q;
  logic [LEN_BITS-1:0]          r;

  logic [R2_BITS-1:0]           r2;
  logic [R2_BITS-1:0]           len1;
  logic [R2_BITS-1:0]           len2;
  logic                         ge1;
  logic                         ge2;
  logic [R2_BITS-1:0]           r2_red;
  logic [MAG_BITS-1:0]          q_next;
  logic signed [SUM_BITS-1:0]   base_w;
  logic signed [SUM_BITS-1:0]   q_w;
  logic signed [SUM_BITS-1:0]   b;
  logic signed [SUM_BITS-1:0]   b_adj;

  // one magnitude bit: remainder doubles, num added, up to two len removed
  always_comb begin
    r2     = R2_BITS'({r, 1'b0}) + (mag_sr[MAG_BITS-1] ? R2_BITS'(num_r) : '0);
    len1   = R2_BITS'(len_r);
    len2   = R2_BITS'({len_r, 1'b0});
    ge2    = (r2 >= len2);
    ge1    = (r2 >= len1);
    r2_red = ge2 ? (r2 - len2) : (ge1 ? (r2 - len1) : r2);
    q_next = MAG_BITS'({q, 1'b0}) + MAG_BITS'({ge2, ge1 && !ge2});
  end

  // signed result with truncation toward zero
  always_comb begin
    base_w = SUM_BITS'(base_r);
    q_w    = SUM_BITS'({1'b0, q});
    b      = neg ? (base_w - q_w) : (base_w + q_w);
    b_adj  = b;
    if (r != '0) begin
      if (pos && (b < 0)) begin
        b_adj = b + SUM_BITS'(1);
      end else if (neg && (b > 0)) begin
        b_adj = b - SUM_BITS'(1);
      end
    end
  end

  assign point = COORD_BITS'(b_adj);

  // iteration control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_BITS'(1));
      if (start) begin
        busy   <= 1'b1;
        cnt    <= CNT_BITS'(MAG_BITS);
        mag_sr <= delta[MAG_BITS-1] ? MAG_BITS'(-delta) : MAG_BITS'(delta);
        neg    <= delta[MAG_BITS-1];
        pos    <= !delta[MAG_BITS-1] && (delta != '0);
        base_r <= base;
        num_r  <= num;
        len_r  <= len;
        q      <= '0;
        r      <= '0;
      end else if (busy) begin
        q      <= q_next;
        r      <= LEN_BITS'(r2_red);
        mag_sr <= {mag_sr[MAG_BITS-2:0], 1'b0};
        cnt    <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the polyline split block. Polylines are driven
// through the vertex channel with random gaps, and the receiver stalls at
// random. A behavioral model of the length walk predicts every point, and
// each point transfer is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import psalf_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 280;
  localparam int MAX_VERTS    = 8;
  localparam int LEN_MAX      = (1 << LEN_BITS) - 1;
  localparam int FRAC_ONE     = 1 << FRAC_SHIFT;
  localparam int FRAC_FULL    = (1 << FRAC_BITS) - 1;

  typedef enum int {SHAPE_SPLIT, SHAPE_EXACT, SHAPE_WHOLE, SHAPE_REJECT} shape_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         first;
    logic                         last;
    logic [FRAC_BITS-1:0]         frac;
    logic [LEN_BITS-1:0]          plen;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  psalf_in_if  vin ();
  psalf_out_if pout ();

  polyline_split_at_length_fraction uut (
    .clk      (clk),
    .rst      (rst),
    .vertices (vin),
    .points   (pout)
  );

  always #5 clk = ~clk;

  // walk state of the model
  logic signed [COORD_BITS-1:0] walk_prev_x = '0;
  logic signed [COORD_BITS-1:0] walk_prev_y = '0;
  logic [LEN_BITS-1:0]          walk_len    = '0;
  logic [LEN_BITS-1:0]          walk_target = '0;
  bit                           walk_split_done = 1'b0;
  bit                           walk_take_all   = 1'b0;
  bit                           walk_rejected   = 1'b0;

  point_t pending_points[$];
  point_t step_points[$];

  int  mismatches  = 0;
  int  points_seen = 0;
  int  quiet_cycles = 0;
  int  hold_req    = 0;
  int  hold_left   = 0;
  int  stall_left  = 0;
  bit  src_gaps_on    = 1'b1;
  bit  sink_stalls_on = 1'b1;

  // floor of the square root, bit by bit from the top
  function automatic longint int_root(input longint s);
    longint res;
    longint cand;
    res = 0;
    for (int b = 18; b >= 0; b--) begin
      cand = res | (longint'(1) << b);
      if (cand * cand <= s) res = cand;
    end
    return res;
  endfunction

  // p + d*num/seg, exact, truncated toward zero
  function automatic longint split_coord(input longint p, d, num, seg);
    return (p * seg + d * num) / seg;
  endfunction

  // gap length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic add_point(input longint px, py, input logic part, status);
    point_t p;
    p.x      = px[COORD_BITS-1:0];
    p.y      = py[COORD_BITS-1:0];
    p.part   = part;
    p.status = status;
    p.last   = 1'b0;
    step_points = {step_points, p};
  endtask

  // model of one vertex: updates the walk and queues its points
  task automatic predict_points(input vertex_t v);
    longint dx, dy, seg, sum, num, prod, walked, target, sx, sy;
    point_t p;
    int n;
    step_points.delete();
    if (v.first) begin
      prod = (longint'(v.plen) * longint'(v.frac)) >>> FRAC_SHIFT;
      walk_prev_x     = v.x;
      walk_prev_y     = v.y;
      walk_len        = '0;
      walk_split_done = 1'b0;
      walk_target     = (prod > LEN_MAX) ? LEN_MAX[LEN_BITS-1:0] : prod[LEN_BITS-1:0];
      walk_take_all   = (v.frac >= FRAC_ONE);
      walk_rejected   = (v.plen == 0) || v.last;
      if (walk_rejected) add_point(0, 0, PART_FIRST, STATUS_REJECT);
      else add_point(v.x, v.y, PART_FIRST, STATUS_OK);
    end else if (walk_rejected) begin
      // rest of a rejected polyline is dropped
    end else if (walk_take_all || walk_split_done) begin
      add_point(v.x, v.y, walk_take_all ? PART_FIRST : PART_SECOND, STATUS_OK);
      walk_prev_x = v.x;
      walk_prev_y = v.y;
    end else begin
      walked = walk_len;
      target = walk_target;
      dx  = longint'(v.x) - longint'(walk_prev_x);
      dy  = longint'(v.y) - longint'(walk_prev_y);
      seg = int_root(dx * dx + dy * dy) << LENGTH_FRAC_BITS;
      sum = walked + seg;
      if (sum > target) begin
        // segment crosses the split: interpolated point to both parts
        num = (target > walked) ? target - walked : 0;
        sx  = split_coord(walk_prev_x, dx, num, seg);
        sy  = split_coord(walk_prev_y, dy, num, seg);
        add_point(sx, sy, PART_FIRST, STATUS_OK);
        add_point(sx, sy, PART_SECOND, STATUS_OK);
        add_point(v.x, v.y, PART_SECOND, STATUS_OK);
        walk_split_done = 1'b1;
      end else if (sum == target) begin
        add_point(v.x, v.y, PART_FIRST, STATUS_OK);
        add_point(v.x, v.y, PART_SECOND, STATUS_OK);
        walk_split_done = 1'b1;
      end else begin
        add_point(v.x, v.y, PART_FIRST, STATUS_OK);
      end
      walk_len    = (sum > LEN_MAX) ? LEN_MAX[LEN_BITS-1:0] : sum[LEN_BITS-1:0];
      walk_prev_x = v.x;
      walk_prev_y = v.y;
    end
    n = step_points.size();
    for (int i = 0; i < n; i++) begin
      p = step_points[i];
      p.last = (i == n - 1);
      pending_points = {pending_points, p};
    end
  endtask

  // one vertex transfer, with an optional gap in front of it
  task automatic send_vertex(input int x, y,
                             input logic first, last,
                             input int frac, plen);
    vertex_t v;
    int gap;
    v.x     = x[COORD_BITS-1:0];
    v.y     = y[COORD_BITS-1:0];
    v.first = first;
    v.last  = last;
    v.frac  = frac[FRAC_BITS-1:0];
    v.plen  = plen[LEN_BITS-1:0];
    gap = (src_gaps_on && $urandom_range(0, 99) >= 55) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      vin.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vin.valid          <= 1'b1;
    vin.vertex_x       <= v.x;
    vin.vertex_y       <= v.y;
    vin.first_vertex   <= v.first;
    vin.last_vertex    <= v.last;
    vin.split_fraction <= v.frac;
    vin.path_length    <= v.plen;
    do @(posedge clk); while (!vin.ready);
    predict_points(v);
  endtask

  // one random polyline of the given shape; counts the vertices sent
  task automatic send_polyline(input shape_t shape, inout int sent);
    logic signed [COORD_BITS-1:0] vx[MAX_VERTS];
    logic signed [COORD_BITS-1:0] vy[MAX_VERTS];
    longint cum[MAX_VERTS];
    longint reach, nx, ny, dx, dy, total;
    logic [FRAC_BITS-1:0] frac;
    logic [LEN_BITS-1:0]  plen;
    int nv, k, r;
    bit single, last;
    nv = $urandom_range(2, MAX_VERTS);
    r  = $urandom_range(0, 99);
    reach = (r < 60) ? longint'($urandom_range(1, 16))
          : (r < 90) ? longint'($urandom_range(17, 1024)) : 0;
    if (reach == 0) begin
      vx[0] = COORD_BITS'($urandom);
      vy[0] = COORD_BITS'($urandom);
    end else begin
      vx[0] = COORD_BITS'(int'($urandom_range(0, 4000)) - 2000);
      vy[0] = COORD_BITS'(int'($urandom_range(0, 4000)) - 2000);
    end
    cum[0] = 0;
    // vertices: short steps, wide steps, anywhere, and repeated points
    for (int i = 1; i < nv; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        vx[i] = vx[i-1];
        vy[i] = vy[i-1];
      end else if (reach == 0) begin
        vx[i] = COORD_BITS'($urandom);
        vy[i] = COORD_BITS'($urandom);
      end else begin
        nx = longint'(vx[i-1]) + longint'($urandom_range(0, 2 * reach)) - reach;
        ny = longint'(vy[i-1]) + longint'($urandom_range(0, 2 * reach)) - reach;
        if (nx > 32767) nx = 32767;
        if (nx < -32768) nx = -32768;
        if (ny > 32767) ny = 32767;
        if (ny < -32768) ny = -32768;
        vx[i] = nx[COORD_BITS-1:0];
        vy[i] = ny[COORD_BITS-1:0];
      end
      dx = longint'(vx[i]) - longint'(vx[i-1]);
      dy = longint'(vy[i]) - longint'(vy[i-1]);
      cum[i] = cum[i-1] + (int_root(dx * dx + dy * dy) << LENGTH_FRAC_BITS);
    end
    total  = cum[nv-1];
    single = 1'b0;
    // path length and fraction per shape
    case (shape)
      SHAPE_SPLIT: begin
        plen = LEN_BITS'((total > LEN_MAX) ? LEN_MAX : total);
        frac = FRAC_BITS'($urandom_range(0, FRAC_ONE - 1));
      end
      SHAPE_EXACT: begin
        k    = $urandom_range(1, nv - 1);
        plen = LEN_BITS'((2 * cum[k] > LEN_MAX) ? LEN_MAX : 2 * cum[k]);
        frac = FRAC_BITS'(FRAC_ONE >> 1);
      end
      SHAPE_WHOLE: begin
        plen = LEN_BITS'($urandom_range(1, LEN_MAX));
        frac = FRAC_BITS'($urandom_range(FRAC_ONE, FRAC_FULL));
      end
      default: begin
        single = 1'($urandom_range(0, 1));
        plen   = single ? LEN_BITS'($urandom_range(0, LEN_MAX)) : '0;
        frac   = FRAC_BITS'($urandom);
      end
    endcase
    for (int i = 0; i < nv; i++) begin
      last = (i == nv - 1) || ((i == 0) ? single : ($urandom_range(0, 9) == 0));
      send_vertex(int'(vx[i]), int'(vy[i]), i == 0, last,
                  (i == 0) ? int'(frac) : int'($urandom_range(0, FRAC_FULL)),
                  (i == 0) ? int'(plen) : int'($urandom_range(0, LEN_MAX)));
    end
    sent += nv;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // no first vertex yet: walk from the origin with split length zero
  task automatic test_from_reset();
    send_vertex(3, 4, 1'b0, 1'b0, 0, 0);
    send_vertex(-5, 4, 1'b0, 1'b1, 0, 0);
  endtask

  // zero path length and single vertex, then their dropped followers
  task automatic test_rejects();
    send_vertex(10, 10, 1'b1, 1'b0, FRAC_ONE >> 1, 0);
    send_vertex(20, 20, 1'b0, 1'b1, FRAC_ONE >> 1, 500);
    send_vertex(7, 7, 1'b1, 1'b1, FRAC_ONE >> 1, 1000);
    send_vertex(0, 0, 1'b0, 1'b0, 0, 0);
  endtask

  // fraction of one or more keeps the whole path in the first part
  task automatic test_take_all();
    send_vertex(-32768, 32767, 1'b1, 1'b0, FRAC_FULL, LEN_MAX);
    send_vertex(32767, -32768, 1'b0, 1'b1, 0, 0);
    send_vertex(1, 2, 1'b1, 1'b0, FRAC_ONE, 300);
    send_vertex(3, 4, 1'b0, 1'b1, 0, 0);
  endtask

  // split length lands exactly on a vertex
  task automatic test_exact_split();
    send_vertex(0, 0, 1'b1, 1'b0, FRAC_ONE >> 1, 10 << LENGTH_FRAC_BITS);
    send_vertex(3, 4, 1'b0, 1'b0, 0, 0);
    send_vertex(6, 8, 1'b0, 1'b1, 0, 0);
  endtask

  // inexact split on a segment heading toward negative coordinates
  task automatic test_interp_negative();
    send_vertex(10, 10, 1'b1, 1'b0, 20000, 50 << LENGTH_FRAC_BITS);
    send_vertex(-20, -30, 1'b0, 1'b1, 0, 0);
  endtask

  // full-range segments, saturating walk, and a zero fraction
  task automatic test_extremes();
    send_vertex(-32768, -32768, 1'b1, 1'b0, FRAC_ONE - 1, LEN_MAX);
    send_vertex(32767, 32767, 1'b0, 1'b0, 0, 0);
    send_vertex(-32768, 32767, 1'b0, 1'b0, 0, 0);
    send_vertex(32767, -32768, 1'b0, 1'b0, 0, 0);
    send_vertex(-32768, -32768, 1'b0, 1'b1, 0, 0);
    send_vertex(5, 5, 1'b1, 1'b0, 0, 1000);
    send_vertex(5, 5, 1'b0, 1'b0, 0, 0);
    send_vertex(9, 8, 1'b0, 1'b1, 0, 0);
  endtask

  // split length never reached; last flag mid-path has no effect
  task automatic test_never_reached();
    send_vertex(0, 0, 1'b1, 1'b0, FRAC_ONE - 1, 100 << LENGTH_FRAC_BITS);
    send_vertex(1, 0, 1'b0, 1'b1, 0, 0);
    send_vertex(1, 1, 1'b0, 1'b0, 0, 0);
    send_vertex(2, 1, 1'b0, 1'b1, 0, 0);
  endtask

  // receiver holds off while vertices keep coming, so the block backs up
  task automatic test_backpressure();
    int sent;
    sent = 0;
    @(posedge clk);
    hold_req = HOLD_CYCLES;
    send_polyline(SHAPE_WHOLE, sent);
    send_polyline(SHAPE_SPLIT, sent);
    send_polyline(SHAPE_EXACT, sent);
  endtask

  // mostly well-formed polylines with random content, some noise
  task automatic test_random_polylines(input int n_items);
    int sent;
    int r;
    sent = 0;
    while (sent < n_items) begin
      // stretches with and without idling on either side
      if ($urandom_range(0, 99) < 8) begin
        src_gaps_on    = ($urandom_range(0, 3) != 0);
        sink_stalls_on = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_vertex($urandom, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, FRAC_FULL), $urandom_range(0, LEN_MAX));
        sent++;
      end else if (r < 16) send_polyline(SHAPE_REJECT, sent);
      else if (r < 26) send_polyline(SHAPE_WHOLE, sent);
      else if (r < 42) send_polyline(SHAPE_EXACT, sent);
      else send_polyline(SHAPE_SPLIT, sent);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver pacing: random stalls plus the requested long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      pout.ready <= 1'b0;
    end else begin
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pout.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pout.ready <= 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap() - 1;
        pout.ready <= 1'b0;
      end else begin
        pout.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // point checker: each transfer against the oldest expected point
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : point_check
    point_t want;
    if (!rst && pout.valid && pout.ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("point %0d unexpected: (%0d,%0d) part %0b status %0b",
                                  points_seen, pout.point_x, pout.point_y,
                                  pout.part_select, pout.status));
      end else begin
        want = pending_points.pop_front();
        if (pout.point_x !== want.x)
          report_mismatch($sformatf("point %0d x: got %0d want %0d",
                                    points_seen, pout.point_x, want.x));
        if (pout.point_y !== want.y)
          report_mismatch($sformatf("point %0d y: got %0d want %0d",
                                    points_seen, pout.point_y, want.y));
        if (pout.part_select !== want.part)
          report_mismatch($sformatf("point %0d part_select: got %0b want %0b",
                                    points_seen, pout.part_select, want.part));
        if (pout.status !== want.status)
          report_mismatch($sformatf("point %0d status: got %0b want %0b",
                                    points_seen, pout.status, want.status));
        if (pout.run_end !== want.last)
          report_mismatch($sformatf("point %0d run_end: got %0b want %0b",
                                    points_seen, pout.run_end, want.last));
      end
      points_seen++;
    end
  end

  // watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if (rst || (vin.valid && vin.ready) || (pout.valid && pout.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d points outstanding",
               quiet_cycles, pending_points.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    vin.valid          = 1'b0;
    vin.vertex_x       = '0;
    vin.vertex_y       = '0;
    vin.first_vertex   = 1'b0;
    vin.last_vertex    = 1'b0;
    vin.split_fraction = '0;
    vin.path_length    = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    test_from_reset();
    test_rejects();
    test_take_all();
    test_exact_split();
    test_interp_negative();
    test_extremes();
    test_never_reached();
    test_backpressure();
    test_random_polylines(RANDOM_ITEMS);

    @(negedge clk);
    vin.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
